// ----- hw/rtl/cfbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_pkg
// Shared types, constants and the DLC length table for the CAN frame byte
// framer.
// ----------------------------------------------------------------------------
package cfbf_pkg;

	// Field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned ID_W     = 29;
	localparam int unsigned DLC_W    = 4;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 15;
	localparam int unsigned FRAMES_W = 12;
	localparam int unsigned LEN_W    = 7;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned MAX_RES  = 5;

	// Framing constants
	localparam logic [BYTE_W-1:0]   SYNC_BYTE       = 8'hAA;
	localparam logic [BYTE_W-1:0]   END_BYTE        = 8'h55;
	localparam logic [COUNT_W-1:0]  MAX_BATCH_BYTES = 15'd16384;
	localparam logic [COUNT_W-1:0]  CAP_RESET       = 15'd16384;
	localparam logic [FRAMES_W-1:0] FRAMES_MAX      = 12'hFFF;
	localparam logic [COUNT_W:0]    FRAME_OVERHEAD  = 16'd5;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 2'd0,
		CMD_HEADER  = 2'd1,
		CMD_PAYLOAD = 2'd2
	} cmd_t;

	// Registered input transaction
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [15:0]       id_lo;
		logic [DLC_W-1:0]  dlc;
		logic [BYTE_W-1:0] pb;
	} item_t;

	// Burst of results caused by one transaction
	typedef struct packed {
		logic [IDX_W-1:0]                n;
		logic [MAX_RES-1:0][BYTE_W-1:0]  bytes;
		logic [COUNT_W-1:0]              base;
		logic [FRAMES_W-1:0]             frames_pre;
		logic [FRAMES_W-1:0]             frames_post;
		logic                            has_end;
		logic                            rejected;
	} burst_t;

	// CAN FD data length code to payload byte count
	function automatic logic [LEN_W-1:0] dlc_len(input logic [DLC_W-1:0] dlc);
		logic [LEN_W-1:0] len;
		case (dlc)
			4'd9:    len = 7'd12;
			4'd10:   len = 7'd16;
			4'd11:   len = 7'd20;
			4'd12:   len = 7'd24;
			4'd13:   len = 7'd32;
			4'd14:   len = 7'd48;
			4'd15:   len = 7'd64;
			default: len = {3'b000, dlc};
		endcase
		return len;
	endfunction

endpackage

// ----- hw/rtl/cfbf_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_in_stage
// Input register: captures one transaction and holds it until the framer
// core takes it.
// ----------------------------------------------------------------------------
module cfbf_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [cfbf_pkg::CMD_W-1:0]    cmd,
	input  logic [cfbf_pkg::ID_W-1:0]     frame_id,
	input  logic [cfbf_pkg::DLC_W-1:0]    dlc_code,
	input  logic [cfbf_pkg::BYTE_W-1:0]   payload_byte,
	input  logic                          free,
	output logic                          valid_s1,
	output cfbf_pkg::item_t               item_s1
);
	import cfbf_pkg::*;

	logic accept;
	logic [ID_W-17:0] id_hi_unused;

	// Stall while a held transaction cannot move on
	assign item_stall   = valid_s1 & ~free;
	assign accept       = item_valid & ~item_stall;
	assign id_hi_unused = frame_id[ID_W-1:16];

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (free) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload; only the low identifier bytes are kept
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd   <= cmd;
			item_s1.id_lo <= frame_id[15:0];
			item_s1.dlc   <= dlc_code;
			item_s1.pb    <= payload_byte;
		end
	end

endmodule

// ----- hw/rtl/cfbf_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_core
// Batch state and decode: turns one transaction into a burst of result bytes
// and updates counters, frame and batch flags in the same cycle.
// ----------------------------------------------------------------------------
module cfbf_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cfbf_pkg::COUNT_W-1:0]   cfg_wr_data,
	input  logic                           take,
	input  cfbf_pkg::item_t                item_s1,
	output cfbf_pkg::burst_t               burst
);
	import cfbf_pkg::*;

	logic [COUNT_W-1:0]  cap_q;
	logic [COUNT_W-1:0]  count_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [LEN_W-1:0]    left_q;
	logic                open_q;
	logic                closed_q;

	logic [COUNT_W-1:0]  cap;
	logic [LEN_W-1:0]    len;
	logic [COUNT_W:0]    need;
	logic [FRAMES_W-1:0] frames_inc;

	logic [COUNT_W-1:0]  count_d;
	logic [FRAMES_W-1:0] frames_d;
	logic [LEN_W-1:0]    left_d;
	logic                open_d;
	logic                closed_d;

	// Saturate capacity and size the frame
	assign cap        = (cap_q > MAX_BATCH_BYTES) ? MAX_BATCH_BYTES : cap_q;
	assign len        = dlc_len(item_s1.dlc);
	assign need       = {1'b0, count_q} + {{(COUNT_W+1-LEN_W){1'b0}}, len} + FRAME_OVERHEAD;
	assign frames_inc = (frames_q == FRAMES_MAX) ? frames_q : frames_q + 12'd1;

	// Decode the transaction into a burst and next state
	always_comb begin
		burst.n           = '0;
		burst.bytes       = '0;
		burst.base        = count_q;
		burst.frames_pre  = frames_q;
		burst.frames_post = frames_q;
		burst.has_end     = 1'b0;
		burst.rejected    = 1'b0;
		count_d  = count_q;
		frames_d = frames_q;
		left_d   = left_q;
		open_d   = open_q;
		closed_d = closed_q;
		case (item_s1.cmd)
			CMD_START: begin
				count_d  = '0;
				frames_d = '0;
				left_d   = '0;
				open_d   = 1'b0;
				closed_d = 1'b0;
			end
			CMD_HEADER: begin
				if (!closed_q && !open_q) begin
					if (need > {1'b0, cap}) begin
						burst.n        = 3'd1;
						burst.rejected = 1'b1;
						closed_d       = 1'b1;
					end else begin
						burst.bytes[0] = SYNC_BYTE;
						burst.bytes[1] = item_s1.id_lo[7:0];
						burst.bytes[2] = item_s1.id_lo[15:8];
						burst.bytes[3] = {1'b0, len};
						burst.bytes[4] = END_BYTE;
						left_d         = len;
						if (len == '0) begin
							burst.n           = 3'd5;
							burst.has_end     = 1'b1;
							burst.frames_post = frames_inc;
							count_d           = count_q + 15'd5;
							frames_d          = frames_inc;
							open_d            = 1'b0;
						end else begin
							burst.n = 3'd4;
							count_d = count_q + 15'd4;
							open_d  = 1'b1;
						end
					end
				end
			end
			CMD_PAYLOAD: begin
				if (open_q && left_q != '0) begin
					burst.bytes[0] = item_s1.pb;
					burst.bytes[1] = END_BYTE;
					left_d         = left_q - 7'd1;
					if (left_q == 7'd1) begin
						burst.n           = 3'd2;
						burst.has_end     = 1'b1;
						burst.frames_post = frames_inc;
						count_d           = count_q + 15'd2;
						frames_d          = frames_inc;
						open_d            = 1'b0;
					end else begin
						burst.n = 3'd1;
						count_d = count_q + 15'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Advance batch state when a transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			frames_q <= '0;
			left_q   <= '0;
			open_q   <= 1'b0;
			closed_q <= 1'b0;
		end else if (take) begin
			count_q  <= count_d;
			frames_q <= frames_d;
			left_q   <= left_d;
			open_q   <= open_d;
			closed_q <= closed_d;
		end
	end

endmodule

// ----- hw/rtl/cfbf_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_emit
// Result register: holds one burst and hands out its results one a cycle while res_stall is low.
// ----------------------------------------------------------------------------
module cfbf_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s1,
	input  cfbf_pkg::burst_t                burst,
	output logic                            free,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [cfbf_pkg::BYTE_W-1:0]     out_byte,
	output logic                            frame_end,
	output logic                            frame_rejected,
	output logic [cfbf_pkg::COUNT_W-1:0]    batch_bytes,
	output logic [cfbf_pkg::FRAMES_W-1:0]   batch_frames
);
	import cfbf_pkg::*;

	burst_t           burst_s2;
	logic             valid_s2;
	logic [IDX_W-1:0] idx_q;
	logic             last;
	logic             take_out;
	logic             load;

	assign last     = (idx_q == burst_s2.n - 3'd1);
	assign take_out = valid_s2 & ~res_stall;
	assign free     = ~valid_s2 | (take_out & last);
	assign load     = valid_s1 & free;

	// Drive the current result
	assign res_valid      = valid_s2;
	assign out_byte       = burst_s2.rejected ? '0 : burst_s2.bytes[idx_q];
	assign frame_rejected = burst_s2.rejected;
	assign frame_end      = burst_s2.rejected | (burst_s2.has_end & last);
	assign batch_bytes    = burst_s2.rejected ? burst_s2.base :
		burst_s2.base + {{(COUNT_W-IDX_W){1'b0}}, idx_q} + 15'd1;
	assign batch_frames   = frame_end ? burst_s2.frames_post : burst_s2.frames_pre;

	// Load a new burst or step through the held one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= (burst.n != '0);
			idx_q    <= '0;
		end else if (take_out) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Capture the burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			burst_s2 <= burst;
		end
	end

endmodule

// ----- hw/rtl/can_frame_byte_framer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_byte_framer_unit
// Packs CAN FD frames into a byte batch for a serial link: start, header and
// payload transactions in, one framed byte per result transaction out.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  --------+---------------------------+--------------------------------------
//  item    | item_valid / item_stall   | cmd, frame_id, dlc_code, payload_byte
//  result  | res_valid / res_stall     | out_byte, frame_end, frame_rejected,
//          |                           | batch_bytes, batch_frames
//  config  | cfg_wr_en                 | cfg_wr_data (batch capacity)
//
//  An item is registered, then decoded combinationally into a burst of 0 to 5
//  results held in the result register, which emits one result a cycle.
//  The single result port paces the items: the next item is taken while
//  the last result of a burst goes out.
//  Reset clears batch state and sets the capacity to 16384.
//  Stalls on the result side hold the burst and back-pressure the item side.
// ----------------------------------------------------------------------------
module can_frame_byte_framer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [cfbf_pkg::CMD_W-1:0]      cmd,
	input  logic [cfbf_pkg::ID_W-1:0]       frame_id,
	input  logic [cfbf_pkg::DLC_W-1:0]      dlc_code,
	input  logic [cfbf_pkg::BYTE_W-1:0]     payload_byte,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [cfbf_pkg::BYTE_W-1:0]     out_byte,
	output logic                            frame_end,
	output logic                            frame_rejected,
	output logic [cfbf_pkg::COUNT_W-1:0]    batch_bytes,
	output logic [cfbf_pkg::FRAMES_W-1:0]   batch_frames,
	input  logic                            cfg_wr_en,
	input  logic [cfbf_pkg::COUNT_W-1:0]    cfg_wr_data
);
	import cfbf_pkg::*;

	logic   valid_s1;
	item_t  item_s1;
	burst_t burst;
	logic   free;
	logic   take;

	// Move the held item into the core once the result register frees up
	assign take = valid_s1 & free;

	cfbf_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.frame_id     (frame_id),
		.dlc_code     (dlc_code),
		.payload_byte (payload_byte),
		.free         (free),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	cfbf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.take        (take),
		.item_s1     (item_s1),
		.burst       (burst)
	);

	cfbf_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.burst          (burst),
		.free           (free),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.out_byte       (out_byte),
		.frame_end      (frame_end),
		.frame_rejected (frame_rejected),
		.batch_bytes    (batch_bytes),
		.batch_frames   (batch_frames)
	);

endmodule

// ----- hw/rtl/cfbf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfbf_checker
// Port-level checks on the framer: result hold under stall, reject and end
// result shape, batch size bound.
// ----------------------------------------------------------------------------
module cfbf_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  logic [cfbf_pkg::BYTE_W-1:0]     out_byte,
	input  logic                            frame_end,
	input  logic                            frame_rejected,
	input  logic [cfbf_pkg::COUNT_W-1:0]    batch_bytes,
	input  logic [cfbf_pkg::FRAMES_W-1:0]   batch_frames
);
	import cfbf_pkg::*;

	// Hold a stalled result transaction
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte)
			&& $stable(batch_bytes) && $stable(frame_end))
		else $error("stalled result changed");

	// A reject closes the frame with a zero byte
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_rejected |-> frame_end && out_byte == '0)
		else $error("malformed reject result");

	// A completed frame ends on the end byte
	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_end && !frame_rejected |-> out_byte == END_BYTE
			&& batch_frames != '0)
		else $error("frame end without end byte");

	// Keep the batch within its hard limit
	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> batch_bytes <= MAX_BATCH_BYTES)
		else $error("batch exceeds maximum size");

endmodule

bind can_frame_byte_framer_unit cfbf_checker u_cfbf_checker (.*);
